// File: sv/urbe_pkg.sv
package urbe_pkg;

	localparam int DEPTH_DEF = 256;

	localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
	localparam logic [2:0] CMD_READ     = 3'd1;
	localparam logic [2:0] CMD_WRITE    = 3'd2;
	localparam logic [2:0] CMD_TX_READY = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       overrun_seen;
		logic       write_last;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_empty;
		logic [7:0]  tx_data;
		logic        tx_valid;
		logic        write_refused;
		logic [7:0]  rx_fill;
		logic [7:0]  tx_fill;
		logic [15:0] overflow_total;
		logic [15:0] overrun_total;
		logic        transmitter_idle;
	} result_t;

	typedef struct packed {
		logic load;
		logic commit;
	} ctl_t;

endpackage

// File: sv/urbe_stream_if.sv
interface urbe_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/urbe_ram.sv
module urbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: sv/urbe_ctrl.sv
module urbe_ctrl import urbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	output ctl_t ctl
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign ctl.load   = in_valid && (state_q == ST_IDLE);
	assign ctl.commit = (state_q == ST_EXEC) && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ctl.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: sv/urbe_datapath.sv
module urbe_datapath import urbe_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl,
	input  item_t   item,
	output result_t result
);
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0]   DEPTH_V = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] fill_of(input logic [AW-1:0] h, input logic [AW-1:0] t);
		logic [AW:0] d;
		d = {1'b0, t} - {1'b0, h} + ((t < h) ? DEPTH_V : '0);
		return d[AW-1:0];
	endfunction

	function automatic logic [7:0] clip(input logic [AW-1:0] f);
		logic [AW+7:0] w;
		w = {8'b0, f};
		return (w > (AW+8)'(255)) ? 8'hFF : w[7:0];
	endfunction

	item_t       item_q;
	result_t     res_q;
	logic [AW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [15:0] overflow_q, overrun_q;
	logic        idle_q;

	logic [AW-1:0] rx_head_n, rx_tail_n, tx_head_n, tx_tail_n;
	logic [15:0] overflow_n, overrun_n;
	logic        idle_n;
	logic [7:0]  rd, txd;
	logic        rd_empty, txv, refused;
	logic        rx_we, tx_we;
	logic [7:0]  rx_rdata, tx_rdata;
	logic        tx_empty, tx_full;
	logic [AW-1:0] rx_tail_adv;

	urbe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we && ctl.commit),
		.waddr (rx_tail_q),
		.wdata (item_q.data_byte),
		.re    (ctl.load),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	urbe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we && ctl.commit),
		.waddr (tx_tail_q),
		.wdata (item_q.data_byte),
		.re    (ctl.load),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	assign tx_empty    = (tx_head_q == tx_tail_q);
	assign tx_full     = (fill_of(tx_head_q, tx_tail_q) == LAST);
	assign rx_tail_adv = adv(rx_tail_q);

	always_comb begin
		rx_head_n  = rx_head_q;
		rx_tail_n  = rx_tail_q;
		tx_head_n  = tx_head_q;
		tx_tail_n  = tx_tail_q;
		overflow_n = overflow_q;
		overrun_n  = overrun_q;
		idle_n     = idle_q;
		rd         = 8'd0;
		rd_empty   = 1'b0;
		txd        = 8'd0;
		txv        = 1'b0;
		refused    = 1'b0;
		rx_we      = 1'b0;
		tx_we      = 1'b0;
		unique case (item_q.command)
			CMD_RX_BYTE: begin
				if (item_q.overrun_seen) begin
					overrun_n = overrun_q + 16'd1;
				end
				rx_we     = 1'b1;
				rx_tail_n = rx_tail_adv;
				if (rx_tail_adv == rx_head_q) begin
					overflow_n = overflow_q + 16'd1;
					rx_head_n  = adv(rx_head_q);
				end
			end
			CMD_READ: begin
				if (rx_head_q == rx_tail_q) begin
					rd_empty = 1'b1;
				end else begin
					rd        = rx_rdata;
					rx_head_n = adv(rx_head_q);
				end
			end
			CMD_WRITE: begin
				if (tx_empty && idle_q) begin
					txd    = item_q.data_byte;
					txv    = 1'b1;
					idle_n = 1'b0;
				end else begin
					if (idle_q) begin
						txd       = tx_rdata;
						txv       = 1'b1;
						idle_n    = 1'b0;
						tx_head_n = adv(tx_head_q);
					end
					if (tx_full && !idle_q) begin
						refused = 1'b1;
					end else begin
						tx_we     = 1'b1;
						tx_tail_n = adv(tx_tail_q);
					end
				end
			end
			CMD_TX_READY: begin
				if (tx_empty) begin
					idle_n = 1'b1;
				end else begin
					txd       = tx_rdata;
					txv       = 1'b1;
					idle_n    = 1'b0;
					tx_head_n = adv(tx_head_q);
				end
			end
			CMD_CLEAR: begin
				rx_head_n  = '0;
				rx_tail_n  = '0;
				tx_head_n  = '0;
				tx_tail_n  = '0;
				overflow_n = 16'd0;
				overrun_n  = 16'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			overflow_q <= 16'd0;
			overrun_q  <= 16'd0;
			idle_q     <= 1'b1;
		end else if (ctl.commit) begin
			rx_head_q  <= rx_head_n;
			rx_tail_q  <= rx_tail_n;
			tx_head_q  <= tx_head_n;
			tx_tail_q  <= tx_tail_n;
			overflow_q <= overflow_n;
			overrun_q  <= overrun_n;
			idle_q     <= idle_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
		if (ctl.commit) begin
			res_q.read_data        <= rd;
			res_q.read_empty       <= rd_empty;
			res_q.tx_data          <= txd;
			res_q.tx_valid         <= txv;
			res_q.write_refused    <= refused;
			res_q.rx_fill          <= clip(fill_of(rx_head_n, rx_tail_n));
			res_q.tx_fill          <= clip(fill_of(tx_head_n, tx_tail_n));
			res_q.overflow_total   <= overflow_n;
			res_q.overrun_total    <= overrun_n;
			res_q.transmitter_idle <= idle_n;
		end
	end

	assign result = res_q;
endmodule

// File: sv/uart_ring_buffer_engine.sv
// Receive and transmit byte rings for one serial port, one event per item on req and
// exactly one status item on rsp. For each item the ring memories are read at the head
// pointers in the accept cycle (registered read), and the item is resolved and written
// back once rsp can take its status item; the next item is accepted in the cycle after that, while the
// previous status item may still wait on rsp. The receive ring drops its oldest byte when
// full, so each ring holds at most DEPTH-1 bytes; fill counts saturate at 255.
module uart_ring_buffer_engine import urbe_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	urbe_stream_if.sink   req,
	urbe_stream_if.source rsp
);
	ctl_t    ctl;
	item_t   item;
	result_t result;

	assign item     = req.data;
	assign rsp.data = result;

	urbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.ctl       (ctl)
	);

	urbe_datapath #(.DEPTH(DEPTH)) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.result (result)
	);
endmodule
